FILE: design/ahcf_pkg.sv
// Package for the ASCII-hex command framer.
// Holds the item mode codes, register indexes, the run type and the hex digit function.
// No dependencies.
`timescale 1ns / 1ps

package ahcf_pkg;

    // Item modes on the input channel.
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_BYTE   = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic REG_SEED     = 1'b0;
    localparam logic REG_END_CHAR = 1'b1;

    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_UPPERA = 8'h41;
    localparam logic [3:0] NIB_TEN     = 4'ha;

    // Up to four characters produced by one item, and the index of the final one.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
    } run_t;

    // Upper-case ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < NIB_TEN) begin
            return CHAR_ZERO + {4'd0, nib};
        end
        return CHAR_UPPERA + {4'd0, nib - NIB_TEN};
    endfunction

endpackage

FILE: design/ascii_hex_command_framer_core.sv
// Top level of the ASCII-hex command framer: input register, configuration
// registers, running checksum, encoder and output serializer. Depends on ahcf_pkg,
// ahcf_encode and ahcf_serializer.
//   Channel | Ports                                      | Direction
//   --------+--------------------------------------------+----------
//   s_      | s_valid, s_ready, s_mode, s_data_value     | in
//   m_      | m_valid, m_ready, m_out_char, m_last_of_run| out
//   cfg_    | cfg_wr_en, cfg_index, cfg_data             | in
//
// Each item yields two to four characters, sent one output beat per cycle while
// m_ready is high; the serializer takes the next run as the final beat leaves.
// An item waits in the input register while the previous run drains.
// Reset (synchronous, aresetn low) clears the checksum to zero, loads the
// register defaults and empties both stages. A stall on m_ready holds the
// current character and, once the input register is full, drops s_ready.
`timescale 1ns / 1ps

module ascii_hex_command_framer_core import ahcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_data_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_of_run,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        hold_valid_reg;
    logic [1:0]  mode_reg;
    logic [15:0] data_reg;
    logic [7:0]  checksum_reg;
    logic [7:0]  checksum_next;
    logic [7:0]  seed_reg;
    logic [7:0]  end_char_reg;
    run_t        enc_run;
    logic        load_ready;
    logic        xfer;

    assign s_ready = !hold_valid_reg;
    assign xfer    = hold_valid_reg && load_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg     <= 8'd85;
            end_char_reg <= 8'd10;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SEED:     seed_reg     <= cfg_data;
                REG_END_CHAR: end_char_reg <= cfg_data;
                default:      seed_reg     <= seed_reg;
            endcase
        end
    end

    // Input register control and the running checksum, updated as each item
    // moves into the serializer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            checksum_reg   <= 8'd0;
        end else begin
            if (s_valid && s_ready) begin
                hold_valid_reg <= 1'b1;
            end else if (xfer) begin
                hold_valid_reg <= 1'b0;
            end
            if (xfer) begin
                checksum_reg <= checksum_next;
            end
        end
    end

    // Input beat payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            data_reg <= s_data_value;
        end
    end

    ahcf_encode u_encode (
        .mode          (mode_reg),
        .data_value    (data_reg),
        .checksum      (checksum_reg),
        .checksum_seed (seed_reg),
        .end_char      (end_char_reg),
        .run           (enc_run),
        .checksum_next (checksum_next)
    );

    ahcf_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_valid    (hold_valid_reg),
        .load_run      (enc_run),
        .load_ready    (load_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: design/ahcf_encode.sv
// Character encoder for the framer: turns one registered item into its run of
// characters and the updated checksum. Depends on ahcf_pkg.
`timescale 1ns / 1ps

module ahcf_encode import ahcf_pkg::*; (
    input  logic [1:0]  mode,
    input  logic [15:0] data_value,
    input  logic [7:0]  checksum,
    input  logic [7:0]  checksum_seed,
    input  logic [7:0]  end_char,
    output run_t        run,
    output logic [7:0]  checksum_next
);

    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic [3:0] cmd;

    assign lo_byte = data_value[7:0];
    assign hi_byte = data_value[15:8];
    assign cmd     = data_value[3:0];

    // Build the characters of the run and the new checksum for each mode.
    always_comb begin
        run.chars     = '0;
        run.last_idx  = 2'd1;
        checksum_next = checksum;
        unique case (mode_t'(mode))
            MODE_START: begin
                run.chars[0]  = CHAR_COLON;
                run.chars[1]  = hex_digit(cmd);
                run.last_idx  = 2'd1;
                checksum_next = checksum_seed - {4'd0, cmd};
            end
            MODE_WORD: begin
                run.chars[0]  = hex_digit(lo_byte[7:4]);
                run.chars[1]  = hex_digit(lo_byte[3:0]);
                run.chars[2]  = hex_digit(hi_byte[7:4]);
                run.chars[3]  = hex_digit(hi_byte[3:0]);
                run.last_idx  = 2'd3;
                checksum_next = checksum - lo_byte - hi_byte;
            end
            MODE_BYTE: begin
                run.chars[0]  = hex_digit(lo_byte[7:4]);
                run.chars[1]  = hex_digit(lo_byte[3:0]);
                run.last_idx  = 2'd1;
                checksum_next = checksum - lo_byte;
            end
            MODE_FINISH: begin
                run.chars[0]  = hex_digit(checksum[7:4]);
                run.chars[1]  = hex_digit(checksum[3:0]);
                run.chars[2]  = end_char;
                run.last_idx  = 2'd2;
            end
            default: begin
                run.last_idx = 2'd1;
            end
        endcase
    end

endmodule

FILE: design/ahcf_serializer.sv
// Output run register for the framer: holds one run of characters and sends
// them one beat at a time. Depends on ahcf_pkg.
`timescale 1ns / 1ps

module ahcf_serializer import ahcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_valid,
    input  run_t       load_run,
    output logic       load_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run
);

    run_t       run_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       at_last;
    logic       beat_done;

    assign at_last       = (idx_reg == run_reg.last_idx);
    assign beat_done     = valid_reg && m_ready;
    assign load_ready    = !valid_reg || (beat_done && at_last);
    assign m_valid       = valid_reg;
    assign m_out_char    = run_reg.chars[idx_reg];
    assign m_last_of_run = at_last;

    // Step through the run; take the next run once the final beat leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load_ready) begin
            valid_reg <= load_valid;
            idx_reg   <= 2'd0;
        end else if (beat_done) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Run payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            run_reg <= load_run;
        end
    end

endmodule
